@@ rtl/ignition_arm_fire_link_watchdog_assert.svh @@
// Assertion macros for the ignition watchdog.
// Both macros sample on clk and are disabled while rst_n is low.
`ifndef IGNITION_ARM_FIRE_LINK_WATCHDOG_ASSERT_SVH
`define IGNITION_ARM_FIRE_LINK_WATCHDOG_ASSERT_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define IAFWD_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle check");

// The consequent must hold in the cycle after the antecedent.
`define IAFWD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle check");

`else

`define IAFWD_ASSERT_SAME(lbl, ante, cons)
`define IAFWD_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

@@ rtl/iafwd_pkg.sv @@
`timescale 1ns / 1ps

package iafwd_pkg;

  // Field and register widths.
  localparam int unsigned TimeW    = 16;
  localparam int unsigned DutyW    = 8;
  localparam int unsigned ElapsedW = 17;
  localparam int unsigned FireW    = 4;
  localparam int unsigned CtrlW    = 8;
  localparam int unsigned CfgIdxW  = 3;

  // Control byte layout.
  localparam int unsigned ArmBit = 4;

  // Saturation value of the elapsed counters.
  localparam logic [ElapsedW-1:0] ElapsedMax = {ElapsedW{1'b1}};

  // Register values after reset.
  localparam logic [TimeW-1:0] DropDelayRst       = 16'd5000;
  localparam logic [TimeW-1:0] FireBeepPeriodRst  = 16'd200;
  localparam logic [TimeW-1:0] FireBeepLengthRst  = 16'd50;
  localparam logic [TimeW-1:0] ArmedBeepPeriodRst = 16'd500;
  localparam logic [TimeW-1:0] ArmedBeepLengthRst = 16'd250;
  localparam logic [TimeW-1:0] IdleBeepPeriodRst  = 16'd1000;
  localparam logic [TimeW-1:0] IdleBeepLengthRst  = 16'd50;
  localparam logic [DutyW-1:0] BuzzerDutyRst      = 8'd94;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    REG_DROP_DELAY        = 3'd0,
    REG_FIRE_BEEP_PERIOD  = 3'd1,
    REG_FIRE_BEEP_LENGTH  = 3'd2,
    REG_ARMED_BEEP_PERIOD = 3'd3,
    REG_ARMED_BEEP_LENGTH = 3'd4,
    REG_IDLE_BEEP_PERIOD  = 3'd5,
    REG_IDLE_BEEP_LENGTH  = 3'd6,
    REG_BUZZER_DUTY       = 3'd7
  } cfg_reg_t;

  // Input command codes.
  typedef enum logic {
    CMD_TICK   = 1'b0,
    CMD_PACKET = 1'b1
  } cmd_t;

  // Saturating increment of an elapsed counter.
  function automatic logic [ElapsedW-1:0] sat_inc(input logic [ElapsedW-1:0] v);
    logic [ElapsedW-1:0] r;
    if (v == ElapsedMax) begin
      r = ElapsedMax;
    end else begin
      r = v + ElapsedW'(1);
    end
    return r;
  endfunction

endpackage

@@ rtl/ignition_arm_fire_link_watchdog.sv @@
`timescale 1ns / 1ps
// Channel  Direction  Handshake             Payload
// in       input      in_valid / in_ready   in_command, in_packet_valid, in_control_byte
// out      output     out_valid / out_ready arm, relay, fire, link lost, buzzer level
// cfg      input      cfg_we (no wait)      cfg_index, cfg_wdata
// Each word passes an input register, combinational update logic and a result register:
// the result is registered after acceptance, one word accepted per cycle when not stalled.
// The input register accepts a word while a result waits, so one word is held at a stall.
// Reset (rst_n low, synchronous) loads the register defaults and clears the state.

`include "ignition_arm_fire_link_watchdog_assert.svh"

module ignition_arm_fire_link_watchdog (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_command,
  input  logic                            in_packet_valid,
  input  logic [iafwd_pkg::CtrlW-1:0]     in_control_byte,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_arm_indicator,
  output logic                            out_relay_enable,
  output logic [iafwd_pkg::FireW-1:0]     out_fire_outputs,
  output logic                            out_link_lost,
  output logic [iafwd_pkg::DutyW-1:0]     out_buzzer_level,
  input  logic                            cfg_we,
  input  logic [iafwd_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [iafwd_pkg::TimeW-1:0]     cfg_wdata
);
  import iafwd_pkg::*;

  // Configuration registers.
  logic [TimeW-1:0] drop_delay_r;
  logic [TimeW-1:0] fire_period_r;
  logic [TimeW-1:0] fire_length_r;
  logic [TimeW-1:0] armed_period_r;
  logic [TimeW-1:0] armed_length_r;
  logic [TimeW-1:0] idle_period_r;
  logic [TimeW-1:0] idle_length_r;
  logic [DutyW-1:0] duty_r;

  // Input register.
  logic             in_full_r;
  cmd_t             cmd_r;
  logic             pkt_valid_r;
  logic [CtrlW-1:0] ctrl_r;

  // Controller state.
  logic                armed_r;
  logic [FireW-1:0]    fire_req_r;
  logic [ElapsedW-1:0] since_pkt_r;
  logic [ElapsedW-1:0] since_beep_r;
  logic [DutyW-1:0]    buzz_r;

  // Next state.
  logic                armed_nxt;
  logic [FireW-1:0]    fire_req_nxt;
  logic [ElapsedW-1:0] since_pkt_nxt;
  logic [ElapsedW-1:0] since_beep_nxt;
  logic [DutyW-1:0]    buzz_nxt;
  logic                lost_nxt;
  logic                live_nxt;
  logic [TimeW-1:0]    period;
  logic [TimeW-1:0]    length;

  // Result register.
  logic             out_valid_r;
  logic             arm_r;
  logic [FireW-1:0] fire_out_r;
  logic             lost_r;
  logic [DutyW-1:0] level_r;

  logic advance;

  // The result register takes a word when it is empty or being drained.
  assign advance  = in_full_r && (!out_valid_r || out_ready);
  assign in_ready = !in_full_r || advance;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drop_delay_r   <= DropDelayRst;
      fire_period_r  <= FireBeepPeriodRst;
      fire_length_r  <= FireBeepLengthRst;
      armed_period_r <= ArmedBeepPeriodRst;
      armed_length_r <= ArmedBeepLengthRst;
      idle_period_r  <= IdleBeepPeriodRst;
      idle_length_r  <= IdleBeepLengthRst;
      duty_r         <= BuzzerDutyRst;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_DROP_DELAY:        drop_delay_r   <= cfg_wdata;
        REG_FIRE_BEEP_PERIOD:  fire_period_r  <= cfg_wdata;
        REG_FIRE_BEEP_LENGTH:  fire_length_r  <= cfg_wdata;
        REG_ARMED_BEEP_PERIOD: armed_period_r <= cfg_wdata;
        REG_ARMED_BEEP_LENGTH: armed_length_r <= cfg_wdata;
        REG_IDLE_BEEP_PERIOD:  idle_period_r  <= cfg_wdata;
        REG_IDLE_BEEP_LENGTH:  idle_length_r  <= cfg_wdata;
        REG_BUZZER_DUTY:       duty_r         <= cfg_wdata[DutyW-1:0];
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_full_r <= 1'b0;
    end else if (in_ready) begin
      in_full_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r       <= cmd_t'(in_command);
      pkt_valid_r <= in_packet_valid;
      ctrl_r      <= in_control_byte;
    end
  end

  // Tick or packet update, link check and buzzer sequencing.
  always_comb begin
    armed_nxt      = armed_r;
    fire_req_nxt   = fire_req_r;
    since_pkt_nxt  = since_pkt_r;
    since_beep_nxt = since_beep_r;
    buzz_nxt       = buzz_r;

    case (cmd_r)
      CMD_TICK: begin
        since_pkt_nxt  = sat_inc(since_pkt_r);
        since_beep_nxt = sat_inc(since_beep_r);
      end
      CMD_PACKET: begin
        if (pkt_valid_r) begin
          since_pkt_nxt = '0;
          armed_nxt     = ctrl_r[ArmBit];
          fire_req_nxt  = ctrl_r[ArmBit] ? ctrl_r[FireW-1:0] : '0;
        end
      end
      default: ;
    endcase

    lost_nxt = since_pkt_nxt > ElapsedW'(drop_delay_r);
    live_nxt = armed_nxt && !lost_nxt;

    // Beep timing follows the mode: firing, then armed, then idle.
    if (fire_req_nxt != '0) begin
      period = fire_period_r;
      length = fire_length_r;
    end else if (armed_nxt) begin
      period = armed_period_r;
      length = armed_length_r;
    end else begin
      period = idle_period_r;
      length = idle_length_r;
    end

    if (since_beep_nxt > ElapsedW'(period)) begin
      since_beep_nxt = '0;
      buzz_nxt       = duty_r;
    end else if (since_beep_nxt > ElapsedW'(length)) begin
      buzz_nxt = '0;
    end
  end

  // State commits when the word moves into the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r      <= 1'b0;
      fire_req_r   <= '0;
      since_pkt_r  <= '0;
      since_beep_r <= '0;
      buzz_r       <= '0;
    end else if (advance) begin
      armed_r      <= armed_nxt;
      fire_req_r   <= fire_req_nxt;
      since_pkt_r  <= since_pkt_nxt;
      since_beep_r <= since_beep_nxt;
      buzz_r       <= buzz_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      arm_r      <= live_nxt;
      fire_out_r <= live_nxt ? fire_req_nxt : '0;
      lost_r     <= lost_nxt;
      level_r    <= buzz_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_arm_indicator = arm_r;
  assign out_relay_enable  = arm_r;
  assign out_fire_outputs  = fire_out_r;
  assign out_link_lost     = lost_r;
  assign out_buzzer_level  = level_r;

  // A fire drive is never shown without the arm condition.
  `IAFWD_ASSERT_SAME(a_fire_needs_arm, out_valid_r && (fire_out_r != '0), arm_r)
  // The arm indicator never shows together with a lost link.
  `IAFWD_ASSERT_SAME(a_arm_not_lost, out_valid_r && arm_r, !lost_r)
  // The input side only stalls when both registers are full and the output is stalled.
  `IAFWD_ASSERT_SAME(a_stall_cause, !in_ready, in_full_r && out_valid_r && !out_ready)
  // A valid packet restarts the link timer.
  `IAFWD_ASSERT_NEXT(a_pkt_restart, advance && (cmd_r == CMD_PACKET) && pkt_valid_r,
                     since_pkt_r == '0)

endmodule
